FILE: rtl/core/sha256_pkg.sv
// shared types, constants and round functions for the sha-256 hasher
package sha256_pkg;

  typedef logic [31:0] word_t;
  typedef logic [0:7][31:0] hash_t;

  // how the word source builds one 64-byte block from buffer and padding
  typedef struct packed {
    logic [6:0] valid_bytes;  // bytes below this index come from the buffer
    logic       marker;       // put the 0x80 byte at index valid_bytes
    logic       with_len;     // put the bit length in the last eight bytes
  } blk_desc_t;

  // control from the sequencer to the compression unit
  typedef struct packed {
    logic start;
    logic chain_init;
  } cmp_ctl_t;

  localparam logic [6:0] BLOCK_BYTES = 7'd64;
  localparam logic [5:0] LEN_START   = 6'd56;
  localparam logic [7:0] PAD_BYTE    = 8'h80;
  localparam logic [2:0] LAST_WORD   = 3'd7;

  localparam hash_t IV = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] K_TABLE = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

  function automatic word_t choose(input word_t e, input word_t f, input word_t g);
    return (e & f) ^ (~e & g);
  endfunction

  function automatic word_t majority(input word_t a, input word_t b, input word_t c);
    return (a & b) ^ (a & c) ^ (b & c);
  endfunction

endpackage

FILE: rtl/core/sha256_msg_buf.sv
// block buffer memory and padded message word source
module sha256_msg_buf (
  input  logic                   clk,
  input  logic                   wr_en,
  input  logic [5:0]             wr_pos,
  input  logic [7:0]             wr_byte,
  input  logic [3:0]             rd_addr,
  input  sha256_pkg::blk_desc_t  desc,
  input  logic [60:0]            byte_count,
  output sha256_pkg::word_t      word
);
  import sha256_pkg::*;

  logic [3:0][7:0] mem [16];
  logic [3:0][7:0] rd_data;
  logic [3:0]      rd_idx;
  logic [63:0]     bit_len;

  // byte write, big-endian lane order within a word
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_pos[5:2]][2'd3 - wr_pos[1:0]] <= wr_byte;
    end
  end

  // registered word read
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
    rd_idx  <= rd_addr;
  end

  assign bit_len = {byte_count, 3'b000};

  // overlay padding marker, zeros and bit length on the stored bytes
  always_comb begin
    logic [5:0] b;
    for (int k = 0; k < 4; k++) begin
      b = {rd_idx, 2'(k)};
      if ({1'b0, b} < desc.valid_bytes) begin
        word[31 - 8*k -: 8] = rd_data[3 - k];
      end else if (desc.marker && ({1'b0, b} == desc.valid_bytes)) begin
        word[31 - 8*k -: 8] = PAD_BYTE;
      end else if (desc.with_len && (b >= LEN_START)) begin
        word[31 - 8*k -: 8] = bit_len[8*(3'd7 - b[2:0]) +: 8];
      end else begin
        word[31 - 8*k -: 8] = 8'h00;
      end
    end
  end

endmodule

FILE: rtl/core/sha256_round.sv
// one sha-256 compression round on the working variables
module sha256_round (
  input  sha256_pkg::hash_t vars,
  input  sha256_pkg::word_t w,
  input  sha256_pkg::word_t k,
  output sha256_pkg::hash_t vars_next
);
  import sha256_pkg::*;

  word_t t1;
  word_t t2;

  // t1 and t2 sums of the round
  assign t1 = vars[7] + big_sigma1(vars[4]) + choose(vars[4], vars[5], vars[6]) + k + w;
  assign t2 = big_sigma0(vars[0]) + majority(vars[0], vars[1], vars[2]);

  // rotate the variables
  assign vars_next = {t1 + t2, vars[0], vars[1], vars[2],
                      vars[3] + t1, vars[4], vars[5], vars[6]};

endmodule

FILE: rtl/core/sha256_compress.sv
// compression unit: schedule window, working variables, chaining words, round counter
module sha256_compress (
  input  logic                  clk,
  input  logic                  rst,
  input  sha256_pkg::cmp_ctl_t  ctl,
  input  sha256_pkg::word_t     w_buf,
  output logic [3:0]            rd_addr,
  output logic                  done,
  output sha256_pkg::hash_t     chain
);
  import sha256_pkg::*;

  typedef enum logic [1:0] {C_IDLE, C_PREP, C_ROUND, C_ADD} cstate_t;

  cstate_t state;
  logic [5:0] rnd;
  hash_t      vars;
  hash_t      vars_next;
  word_t      win [16];
  word_t      sched_w;
  word_t      w;

  // message schedule word, from the buffer for the first sixteen rounds
  assign sched_w = small_sigma1(win[14]) + win[9] + small_sigma0(win[1]) + win[0];
  assign w       = (rnd[5:4] == 2'b00) ? w_buf : sched_w;

  sha256_round u_round (
    .vars      (vars),
    .w         (w),
    .k         (K_TABLE[rnd]),
    .vars_next (vars_next)
  );

  // prefetch the buffer word for the next round
  assign rd_addr = (state == C_ROUND) ? 4'(rnd[3:0] + 4'd1) : 4'd0;
  assign done    = (state == C_ADD);

  // sequencer and chaining state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      rnd   <= '0;
      chain <= IV;
    end else begin
      case (state)
        C_IDLE: begin
          if (ctl.start) begin
            state <= C_PREP;
          end
        end
        C_PREP: begin
          vars  <= chain;
          rnd   <= '0;
          state <= C_ROUND;
        end
        C_ROUND: begin
          vars <= vars_next;
          for (int i = 0; i < 15; i++) begin
            win[i] <= win[i+1];
          end
          win[15] <= w;
          rnd     <= 6'(rnd + 6'd1);
          if (rnd == 6'd63) begin
            state <= C_ADD;
          end
        end
        C_ADD: begin
          for (int i = 0; i < 8; i++) begin
            chain[i] <= chain[i] + vars[i];
          end
          state <= C_IDLE;
        end
        default: begin
          state <= C_IDLE;
        end
      endcase
      if (ctl.chain_init) begin
        chain <= IV;
      end
    end
  end

endmodule

FILE: rtl/core/sha256_message_hasher.sv
// sha-256 message hasher top level: byte intake, padding sequencer, digest output
//
//  channel   dir  tdata                          tuser          tlast
//  s_axis    in   [7:0] data_byte                byte_present   message_end
//  m_axis    out  [31:0] digest_word,            -              digest_last
//                 [34:32] word_number
//
// a byte that does not fill a block leaves intake ready for the next one; the byte that fills
// it starts a compression (one start handoff, one prefetch, 64 rounds, one chaining add) in
// the single shared round unit, with intake held off until it ends. message end adds one or
// two padding blocks, then eight digest transfers, one per cycle while m_tready is high.
// rst is synchronous; a stalled m_tready holds the current digest word.
module sha256_message_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // byte_present
  input  logic        s_tlast,   // message_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_number, rest zero
  output logic        m_tlast    // digest_last
);
  import sha256_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_DATA, S_PAD1, S_PAD2, S_OUT} state_t;

  state_t     state;
  logic [60:0] count;
  logic [60:0] count_inc;
  logic [60:0] count_after;
  logic [2:0]  idx;
  logic        end_pending;
  blk_desc_t   desc;
  blk_desc_t   pad_desc;
  cmp_ctl_t    ctl;
  logic        accept;
  logic        full;
  logic [5:0]  pad_pos;
  logic        pad_two;
  logic [3:0]  rd_addr;
  word_t       w_buf;
  logic        done;
  hash_t       chain;

  assign accept      = s_tvalid && s_tready;
  assign count_inc   = 61'(count + 61'd1);
  assign count_after = s_tuser ? count_inc : count;
  assign full        = s_tuser && (count[5:0] == 6'd63);

  // first padding block: marker after the last byte, length if it still fits
  assign pad_pos  = (state == S_DATA) ? count[5:0] : count_after[5:0];
  assign pad_two  = (pad_pos >= LEN_START);
  assign pad_desc = '{valid_bytes: {1'b0, pad_pos}, marker: 1'b1, with_len: !pad_two};

  sha256_msg_buf u_buf (
    .clk        (clk),
    .wr_en      (accept && s_tuser),
    .wr_pos     (count[5:0]),
    .wr_byte    (s_tdata),
    .rd_addr    (rd_addr),
    .desc       (desc),
    .byte_count (count),
    .word       (w_buf)
  );

  sha256_compress u_cmp (
    .clk     (clk),
    .rst     (rst),
    .ctl     (ctl),
    .w_buf   (w_buf),
    .rd_addr (rd_addr),
    .done    (done),
    .chain   (chain)
  );

  // handshake and output payload
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tlast  = (idx == LAST_WORD);
  assign m_tdata  = {5'b0, idx, chain[idx]};

  // message sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      count       <= '0;
      idx         <= '0;
      end_pending <= 1'b0;
      ctl         <= '0;
    end else begin
      ctl <= '0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            count <= count_after;
            if (full) begin
              desc        <= '{valid_bytes: BLOCK_BYTES, marker: 1'b0, with_len: 1'b0};
              ctl.start   <= 1'b1;
              end_pending <= s_tlast;
              state       <= S_DATA;
            end else if (s_tlast) begin
              desc      <= pad_desc;
              ctl.start <= 1'b1;
              state     <= pad_two ? S_PAD1 : S_PAD2;
            end
          end
        end
        S_DATA: begin
          if (done) begin
            if (end_pending) begin
              desc      <= pad_desc;
              ctl.start <= 1'b1;
              state     <= pad_two ? S_PAD1 : S_PAD2;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_PAD1: begin
          // second padding block holds only zeros and the length
          if (done) begin
            desc      <= '{valid_bytes: 7'd0, marker: 1'b0, with_len: 1'b1};
            ctl.start <= 1'b1;
            state     <= S_PAD2;
          end
        end
        S_PAD2: begin
          if (done) begin
            idx   <= '0;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (m_tready) begin
            idx <= 3'(idx + 3'd1);
            if (idx == LAST_WORD) begin
              count          <= '0;
              ctl.chain_init <= 1'b1;
              state          <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/core/sha256_checker.sv
// port-level checks on the sha-256 hasher and their binding
module sha256_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);

  // a stalled digest word holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("digest word changed under stall");

  // no intake while the digest is being delivered
  a_excl: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("input ready during digest output");

  // digest words come out in order without gaps
  a_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=>
      m_tvalid && (m_tdata[34:32] == 3'($past(m_tdata[34:32]) + 3'd1)))
    else $error("digest word order broken");

  // last flag only on word seven
  a_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (m_tdata[34:32] == 3'd7)))
    else $error("digest_last on wrong word");

  // intake resumes right after the final digest transfer
  a_resume: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && m_tlast |=> s_tready && !m_tvalid)
    else $error("no return to intake after digest");

endmodule

bind sha256_message_hasher sha256_checker u_chk (.*);

FILE: dv/sha256_message_hasher_tb.sv
// self-checking stream testbench for the sha-256 message hasher
`timescale 1ns / 1ps

module sha256_message_hasher_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 200;
  localparam int PHASE_ITEMS = 4;
  localparam int SHOWN_ERRORS = 10;

  localparam logic [255:0] EMPTY_DIGEST =
    256'he3b0c442_98fc1c14_9afbf4c8_996fb924_27ae41e4_649b934c_a495991b_7852b855;
  localparam logic [255:0] ABC_DIGEST =
    256'hba7816bf_8f01cfea_414140de_5dae2223_b00361a3_96177a9c_b410ff61_f20015ad;

  localparam logic [0:7][31:0] START_H = {
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [0:63][31:0] ROUND_K = {
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // one message item as it travels on the slave side
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       msg_end;
  } msg_item_t;

  // directed row: item plus an optional hand-typed digest
  typedef struct packed {
    logic [7:0]   data;
    logic         has_byte;
    logic         msg_end;
    logic         typed;
    logic [255:0] digest;
  } plan_row_t;

  // one expected digest word
  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        fin;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tuser = 1'b0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic        m_tlast;

  sha256_message_hasher u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // 20 ns clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // hasher state mirrored in the testbench
  logic [31:0]  chain_h [8];
  logic [7:0]   blk [64];
  logic [60:0]  byte_total;
  digest_word_t digest_q [$];

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int errors = 0;
  int cycles = 0;
  int msg_count = 0;
  int item_count = 0;
  int word_count = 0;
  int long_msgs = 0;

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // 64 rounds over the block buffer, folded into the chaining words
  function automatic void fold_block();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    int r;
    for (r = 0; r < 16; r++) w[r] = {blk[4*r], blk[4*r+1], blk[4*r+2], blk[4*r+3]};
    for (r = 16; r < 64; r++) begin
      s0 = ror32(w[r-15], 7) ^ ror32(w[r-15], 18) ^ (w[r-15] >> 3);
      s1 = ror32(w[r-2], 17) ^ ror32(w[r-2], 19) ^ (w[r-2] >> 10);
      w[r] = w[r-16] + s0 + w[r-7] + s1;
    end
    a = chain_h[0]; b = chain_h[1]; c = chain_h[2]; d = chain_h[3];
    e = chain_h[4]; f = chain_h[5]; g = chain_h[6]; h = chain_h[7];
    for (r = 0; r < 64; r++) begin
      s1 = ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25);
      t1 = h + s1 + ((e & f) ^ (~e & g)) + ROUND_K[r] + w[r];
      s0 = ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22);
      t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain_h[0] += a; chain_h[1] += b; chain_h[2] += c; chain_h[3] += d;
    chain_h[4] += e; chain_h[5] += f; chain_h[6] += g; chain_h[7] += h;
  endfunction

  function automatic void restart_hash();
    int i;
    for (i = 0; i < 8; i++) chain_h[i] = START_H[i];
    byte_total = '0;
  endfunction

  // absorb one item; returns 1 with the digest when it closes a message
  function automatic bit hash_item(input msg_item_t it, output logic [255:0] dg);
    logic [5:0]  pos;
    logic [63:0] bit_len;
    int i;
    dg = '0;
    if (it.has_byte) begin
      pos = byte_total[5:0];
      blk[pos] = it.data;
      byte_total = byte_total + 61'd1;
      if (pos == 6'd63) fold_block();
    end
    if (!it.msg_end) return 1'b0;
    // padding: marker, zeros, big-endian bit length
    pos = byte_total[5:0];
    blk[pos] = 8'h80;
    for (i = pos + 1; i < 64; i++) blk[i] = 8'h00;
    if (pos > 6'd55) begin
      fold_block();
      for (i = 0; i < 56; i++) blk[i] = 8'h00;
    end
    bit_len = {byte_total, 3'b000};
    for (i = 0; i < 8; i++) blk[56+i] = bit_len[63-8*i -: 8];
    fold_block();
    for (i = 0; i < 8; i++) dg[255-32*i -: 32] = chain_h[i];
    restart_hash();
    return 1'b1;
  endfunction

  // drive one item, wait for the transfer, then record what it should produce
  task automatic push_item(input msg_item_t it, input bit typed, input logic [255:0] known);
    logic [255:0] dg;
    int i;
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= it.data;
    s_tuser  <= it.has_byte;
    s_tlast  <= it.msg_end;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (hash_item(it, dg)) begin
      if (typed) dg = known;
      for (i = 0; i < 8; i++)
        digest_q.push_back('{dg[255-32*i -: 32], 3'(i), (i == 7)});
      msg_count++;
    end
    if (it.has_byte || it.msg_end) item_count++;
  endtask

  // hold the sender off until every digest word is back
  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  // random message of len bytes, with stray ignored items mixed in
  task automatic random_message(input int len);
    msg_item_t it;
    bit end_on_byte;
    int i;
    end_on_byte = (len > 0) && ($urandom_range(1) == 1);
    for (i = 0; i < len; i++) begin
      if ($urandom_range(9) == 0) begin
        it = '{8'($urandom_range(255)), 1'b0, 1'b0};
        push_item(it, 1'b0, '0);
      end
      it = '{8'($urandom_range(255)), 1'b1, end_on_byte && (i == len - 1)};
      push_item(it, 1'b0, '0);
    end
    if (!end_on_byte) begin
      it = '{8'($urandom_range(255)), 1'b0, 1'b1};
      push_item(it, 1'b0, '0);
    end
  endtask

  // compare one digest transfer against the oldest expectation
  task automatic check_word();
    digest_word_t want;
    word_count++;
    if (digest_q.size() == 0) begin
      errors++;
      if (errors <= SHOWN_ERRORS)
        $display("unexpected digest transfer: word %h idx %0d last %b",
                 m_tdata[31:0], m_tdata[34:32], m_tlast);
      return;
    end
    want = digest_q.pop_front();
    if (m_tdata[31:0] !== want.word || m_tdata[34:32] !== want.idx
        || m_tlast !== want.fin) begin
      errors++;
      if (errors <= SHOWN_ERRORS)
        $display("digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                 want.word, want.idx, want.fin, m_tdata[31:0], m_tdata[34:32], m_tlast);
    end
  endtask

  // master side: check transfers and stall at random
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) check_word();
    m_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  plan_row_t plan [12];
  int src_plan [4] = '{0, 47, 0, 19};
  int sink_plan [4] = '{0, 0, 47, 19};
  // empty message, two-block padding, full block then padding
  int boundary_len [4] = '{0, 56, 0, 64};

  initial begin
    int p, k, n;
    msg_item_t it;
    // directed rows: empty message, ignored items, known vector, byte extremes
    plan = '{
      '{8'h00, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
      '{8'hff, 1'b0, 1'b0, 1'b0, 256'h0},
      '{8'h61, 1'b1, 1'b0, 1'b0, 256'h0},
      '{8'ha5, 1'b0, 1'b0, 1'b0, 256'h0},
      '{8'h62, 1'b1, 1'b0, 1'b0, 256'h0},
      '{8'h63, 1'b1, 1'b1, 1'b1, ABC_DIGEST},
      '{8'h00, 1'b1, 1'b1, 1'b0, 256'h0},
      '{8'hff, 1'b1, 1'b1, 1'b0, 256'h0},
      '{8'h5a, 1'b1, 1'b0, 1'b0, 256'h0},
      '{8'hc3, 1'b0, 1'b1, 1'b0, 256'h0},
      '{8'hff, 1'b0, 1'b1, 1'b1, EMPTY_DIGEST},
      '{8'h80, 1'b1, 1'b1, 1'b0, 256'h0}
    };
    restart_hash();
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < 12; k++) begin
      it = '{plan[k].data, plan[k].has_byte, plan[k].msg_end};
      push_item(it, plan[k].typed, plan[k].digest);
    end

    // random messages under each idling mix; one padding boundary per phase
    for (p = 0; p < 4; p++) begin
      src_idle_pct = src_plan[p];
      sink_stall_pct = sink_plan[p];
      random_message(boundary_len[p]);
      long_msgs++;
      hold_until_drained();
      n = item_count + PHASE_ITEMS;
      while (item_count < n) begin
        random_message($urandom_range(12));
      end
    end

    // wait for the tail, then allow for any block still in flight
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d messages (%0d on padding boundaries) from %0d items",
             msg_count, long_msgs, item_count);
    $display("checked %0d digest words under four idle/stall mixes", word_count);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("mismatches: %0d", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
